FILE: hw/rtl/salc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package salc_pkg;
	localparam int MaxSets = 1024;
	localparam int MaxWays = 8;
	localparam int SetBits = 10;
	localparam int WayBits = 3;
	localparam int TagBits = 32;
	localparam int RowBits = MaxWays * (TagBits + 2);

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_FETCH = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_BLOCK = 2'd0,
		REG_WAYS  = 2'd1,
		REG_SIZE  = 2'd2,
		REG_NONE  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] address;
	} in_word_t;

	typedef struct packed {
		logic hit;
		logic evicted;
		logic victim_dirty;
	} out_word_t;

	typedef struct packed {
		logic             valid;
		logic             dirty;
		logic [TagBits-1:0] tag;
	} line_t;

	typedef line_t [MaxWays-1:0] row_t;

	typedef struct packed {
		logic clear;
		logic read;
		logic update;
		logic [SetBits-1:0] clr_set;
	} cmd_t;
endpackage
`default_nettype wire

FILE: hw/rtl/salc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module salc_ctrl
	import salc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      cmd
);
	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_LOOK  = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	state_t state_q;
	logic [SetBits-1:0] clr_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	always_comb begin
		cmd.clear   = (state_q == ST_CLEAR);
		cmd.clr_set = clr_q;
		cmd.read    = in_valid && in_ready;
		cmd.update  = (state_q == ST_LOOK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SetBits'(MaxSets - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (in_valid) state_q <= ST_LOOK;
				ST_LOOK: state_q <= ST_OUT;
				ST_OUT:  if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/salc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module salc_dp
	import salc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cmd_t     cmd,
	input  wire in_word_t in_word,
	input  wire logic     cfg_valid,
	input  wire logic     cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [31:0] cfg_data,
	output out_word_t     out_word
);
	logic [2:0] bs_q;
	logic [1:0] wl_q;
	logic [3:0] cs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q <= 3'd4;
			wl_q <= 2'd0;
			cs_q <= 4'd10;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_BLOCK: bs_q <= cfg_data[2:0];
				REG_WAYS:  wl_q <= cfg_data[1:0];
				REG_SIZE:  cs_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// geometry
	logic signed [5:0] sdiff;
	logic [3:0] sl;
	logic [3:0] nw;
	always_comb begin
		sdiff = $signed({2'b0, cs_q}) - $signed({3'b0, bs_q}) - $signed({4'b0, wl_q});
		if (sdiff <= 0)       sl = 4'd0;
		else if (sdiff >= 10) sl = 4'd10;
		else                  sl = sdiff[3:0];
		nw = 4'd1 << wl_q;
	end

	row_t ibank [MaxSets];
	row_t dbank [MaxSets];
	row_t row_s1;
	logic [1:0] kind_s1;
	logic [SetBits-1:0] set_s1;
	logic [TagBits-1:0] tag_s1;
	logic [31:0] blk;
	logic [SetBits-1:0] set_c;

	always_comb begin
		blk   = in_word.address >> bs_q;
		set_c = blk[SetBits-1:0] & SetBits'((11'd1 << sl) - 11'd1);
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			kind_s1 <= in_word.kind;
			set_s1  <= set_c;
			tag_s1  <= TagBits'(blk >> sl);
			row_s1  <= (in_word.kind == KIND_FETCH) ? ibank[set_c] : dbank[set_c];
		end
	end

	// hit, first free and reordered row
	row_t nrow;
	out_word_t res;
	logic found, empty, stop;
	logic [WayBits-1:0] p;
	logic [MaxWays-2:0] nv;
	line_t keep;
	always_comb begin
		nrow  = row_s1;
		res   = '0;
		found = 1'b0;
		empty = 1'b0;
		stop  = 1'b0;
		p     = '0;
		// nv: next slot is in use and valid
		for (int b = 0; b < MaxWays - 1; b++)
			nv[b] = (4'(b + 1) < nw) && row_s1[b + 1].valid;
		for (int b = 0; b < MaxWays; b++) begin
			if (!found && !empty && 4'(b) < nw) begin
				if (row_s1[b].valid && row_s1[b].tag == tag_s1) begin
					found = 1'b1;
					p     = WayBits'(b);
				end else if (!row_s1[b].valid) begin
					empty = 1'b1;
					p     = WayBits'(b);
				end
			end
		end
		keep.valid = 1'b1;
		keep.tag   = tag_s1;
		keep.dirty = (kind_s1 == KIND_WRITE) || (found && row_s1[p].dirty);
		if (found) begin
			res.hit = 1'b1;
			// lines above the hit slide down one slot, hit line lands at end of valid run
			for (int b = 0; b < MaxWays - 1; b++) begin
				if (!stop && 4'(b) >= {1'b0, p}) begin
					if (nv[b]) nrow[b] = row_s1[b + 1];
					else begin
						nrow[b] = keep;
						stop    = 1'b1;
					end
				end
			end
			if (!stop) nrow[MaxWays-1] = keep;
		end else if (empty) begin
			nrow[p] = keep;
		end else begin
			res.evicted      = 1'b1;
			res.victim_dirty = row_s1[0].dirty;
			for (int b = 0; b < MaxWays - 1; b++) begin
				if (4'(b + 1) < nw) nrow[b] = row_s1[b + 1];
				else if (4'(b + 1) == nw) nrow[b] = keep;
			end
			if (nw == 4'(MaxWays)) nrow[MaxWays-1] = keep;
		end
		if (kind_s1 == KIND_NONE) res = '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			ibank[cmd.clr_set] <= '0;
			dbank[cmd.clr_set] <= '0;
		end else if (cmd.update && kind_s1 != KIND_NONE) begin
			if (kind_s1 == KIND_FETCH) ibank[set_s1] <= nrow;
			else dbank[set_s1] <= nrow;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) out_word <= res;
	end
endmodule
`default_nettype wire

FILE: hw/rtl/set_assoc_lru_split_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// Split I/D set-associative tag store with LRU replacement, write-back and
// write-allocate. One word in gives one word out. Each access goes in order
// through: accept and read the set row, compare/reorder and write it back,
// present the result. After reset a clearing pass over all 1024 sets wipes
// both stores before the first word is accepted; configuration writes are
// taken at any time and should only be issued while idle.
module set_assoc_lru_split_cache
	import salc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_word_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_word_t      out_data,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [31:0] cfg_data
);
	cmd_t cmd;

	assign cfg_ready = 1'b1;

	salc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd
	);

	salc_dp u_dp (
		.clk, .arst_n, .cmd, .in_word(in_data), .cfg_valid, .cfg_ready,
		.cfg_index, .cfg_data, .out_word(out_data)
	);

	a_one_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("accept while result pending");
	a_ev_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.hit && out_data.evicted)) else $error("hit and evict");
	a_vd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.victim_dirty |-> out_data.evicted) else $error("dirty w/o evict");
endmodule
`default_nettype wire
